@@ src/dfsam_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package dfsam_pkg;

  // Graph size and field widths
  localparam int unsigned MaxVertices = 16;
  localparam int unsigned VtxW        = 4;
  localparam int unsigned CntW        = 5;
  localparam int unsigned RowW        = MaxVertices;

  typedef logic [VtxW-1:0] vtx_t;
  typedef logic [CntW-1:0] cnt_t;
  typedef logic [RowW-1:0] row_t;

  // Input word opcodes
  localparam logic OpWrite = 1'b0;
  localparam logic OpRun   = 1'b1;

  localparam cnt_t VcountReset = cnt_t'(MaxVertices);

endpackage
`default_nettype wire

@@ src/dfsam_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Input channel: command words
interface dfsam_in_if;
  import dfsam_pkg::*;
  logic valid;
  logic ready;
  logic opcode;
  vtx_t vertex;
  row_t row_bits;

  modport source (output valid, output opcode, output vertex, output row_bits, input ready);
  modport sink   (input valid, input opcode, input vertex, input row_bits, output ready);
endinterface

// Output channel: visited vertices in preorder
interface dfsam_out_if;
  import dfsam_pkg::*;
  logic valid;
  logic ready;
  vtx_t visited_vertex;
  logic last;

  modport source (output valid, output visited_vertex, output last, input ready);
  modport sink   (input valid, input visited_vertex, input last, output ready);
endinterface
`default_nettype wire

@@ src/dfs_adjacency_matrix.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Word
// --------  ---  ---------------------------------------------------
// in_if     in   opcode, vertex, row_bits (row write or walk start)
// out_if    out  visited_vertex, last (preorder, last on final vertex)
// cfg_*     in   vertex_count, 5 bits, written when cfg_we_i is high
//
// A walk passes through StArd and StSrch for each newly visited vertex
// and through StSrch, StSrd, StSload and StArd for each backtrack step,
// set by the registered reads of the adjacency memory and the stack memory.
// Reset clears the matrix at once through per-row valid bits.
// A full output register stalls the walk in its search state.
module dfs_adjacency_matrix (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire dfsam_pkg::cnt_t  cfg_wdata_i,
  dfsam_in_if.sink              in_if,
  dfsam_out_if.source           out_if
);
  import dfsam_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StArd   = 3'd1;
  localparam logic [2:0] StSrch  = 3'd2;
  localparam logic [2:0] StSrd   = 3'd3;
  localparam logic [2:0] StSload = 3'd4;

  logic [2:0] state_q, state_d;
  cnt_t       vcount_q;
  vtx_t       cur_q, cur_d;
  vtx_t       pend_q, pend_d;
  row_t       visited_q, visited_d;
  cnt_t       depth_q, depth_d;
  row_t       adj_vld_q;
  row_t       adj_rd_q;
  logic       adj_rd_vld_q;
  vtx_t       stk_rd_q;
  logic       out_vld_q, out_vld_d;
  vtx_t       out_vtx_q;
  logic       out_last_q;

  row_t       adj_mem [MaxVertices];
  vtx_t       stk_mem [MaxVertices];

  cnt_t       n_eff;
  row_t       live_mask;
  logic       in_range;
  logic       accept;
  logic       adj_we;
  logic       stk_we;
  vtx_t       stk_waddr;
  vtx_t       stk_wdata;
  vtx_t       stk_raddr;
  row_t       row_live;
  row_t       cand;
  logic       found;
  vtx_t       next_vtx;
  logic       out_free;
  logic       emit;
  logic       emit_last;

  // Effective vertex count and live-row mask
  always_comb begin
    n_eff = (vcount_q > cnt_t'(MaxVertices)) ? cnt_t'(MaxVertices) : vcount_q;
    if (n_eff >= cnt_t'(RowW)) begin
      live_mask = '1;
    end else begin
      live_mask = row_t'((row_t'(1) << n_eff) - row_t'(1));
    end
  end

  assign in_range = ({1'b0, in_if.vertex} < n_eff);
  assign in_if.ready = (state_q == StIdle);
  assign accept = in_if.valid && in_if.ready;
  assign adj_we = accept && (in_if.opcode == OpWrite) && in_range;

  // Lowest unvisited neighbor of the current vertex
  assign row_live = (adj_rd_vld_q ? adj_rd_q : '0) & live_mask;
  assign cand = row_live & ~visited_q;
  assign found = |cand;
  always_comb begin
    next_vtx = '0;
    for (int i = MaxVertices - 1; i >= 0; i--) begin
      if (cand[i]) begin
        next_vtx = vtx_t'(i);
      end
    end
  end

  assign out_free = !out_vld_q || out_if.ready;
  assign stk_raddr = vtx_t'(depth_q - cnt_t'(1));

  // Walk sequencer
  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    pend_d    = pend_q;
    visited_d = visited_q;
    depth_d   = depth_q;
    stk_we    = 1'b0;
    stk_waddr = depth_q[VtxW-1:0];
    stk_wdata = next_vtx;
    emit      = 1'b0;
    emit_last = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (accept && (in_if.opcode == OpRun)) begin
          visited_d = '0;
          depth_d   = '0;
          if (in_range) begin
            visited_d = row_t'(1) << in_if.vertex;
            pend_d    = in_if.vertex;
            cur_d     = in_if.vertex;
            depth_d   = cnt_t'(1);
            stk_we    = 1'b1;
            stk_waddr = '0;
            stk_wdata = in_if.vertex;
            state_d   = StArd;
          end
        end
      end
      StArd: begin
        state_d = StSrch;
      end
      StSrch: begin
        if (found) begin
          // descend: release the held vertex, push the new one
          if (out_free) begin
            emit      = 1'b1;
            pend_d    = next_vtx;
            visited_d = visited_q | (row_t'(1) << next_vtx);
            stk_we    = 1'b1;
            depth_d   = depth_q + cnt_t'(1);
            cur_d     = next_vtx;
            state_d   = StArd;
          end
        end else if (depth_q == cnt_t'(1)) begin
          // walk done: release the held vertex as the last one
          if (out_free) begin
            emit      = 1'b1;
            emit_last = 1'b1;
            depth_d   = '0;
            state_d   = StIdle;
          end
        end else begin
          depth_d = depth_q - cnt_t'(1);
          state_d = StSrd;
        end
      end
      StSrd: begin
        state_d = StSload;
      end
      StSload: begin
        cur_d   = stk_rd_q;
        state_d = StArd;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign out_vld_d = emit ? 1'b1 : (out_if.ready ? 1'b0 : out_vld_q);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      vcount_q  <= VcountReset;
      visited_q <= '0;
      depth_q   <= '0;
      adj_vld_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      visited_q <= visited_d;
      depth_q   <= depth_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
      end
      if (adj_we) begin
        adj_vld_q[in_if.vertex] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    pend_q <= pend_d;
    if (emit) begin
      out_vtx_q  <= pend_q;
      out_last_q <= emit_last;
    end
  end

  // Adjacency memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (adj_we) begin
      adj_mem[in_if.vertex] <= in_if.row_bits & live_mask;
    end
    adj_rd_q     <= adj_mem[cur_q];
    adj_rd_vld_q <= adj_vld_q[cur_q];
  end

  // Stack memory: one write, one registered read of the top
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rd_q <= stk_mem[stk_raddr];
  end

  assign out_if.valid          = out_vld_q;
  assign out_if.visited_vertex = out_vtx_q;
  assign out_if.last           = out_last_q;

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import dfsam_pkg::*;

  localparam int unsigned SettleCycles  = 100;
  localparam int unsigned WatchdogLimit = 4000;

  typedef struct packed {
    vtx_t vertex;
    logic last;
  } visit_t;

  // Mirror of the graph and the preorder each walk must produce
  class preorder_board;
    row_t        adjacency [MaxVertices];
    cnt_t        vertex_count;
    visit_t      preorder_q [$];
    int unsigned mismatches;

    function new();
      foreach (adjacency[i]) adjacency[i] = '0;
      vertex_count = VcountReset;
      mismatches   = 0;
    endfunction

    task report(string what);
      $display("[%0t] MISMATCH: %s", $time, what);
      mismatches++;
    endtask

    // Apply one accepted command word to the mirror
    function void note_word(logic opcode, vtx_t vertex, row_t row_bits);
      int unsigned n;
      row_t        mask;
      n = vertex_count;
      if (n > MaxVertices) n = MaxVertices;
      if (n > RowW) n = RowW;
      mask = (n >= RowW) ? '1 : row_t'((1 << n) - 1);
      if (opcode == OpWrite) begin
        if (vertex < n) adjacency[vertex] = row_bits & mask;
      end else begin
        walk_preorder(vertex, n, mask);
      end
    endfunction

    // Depth-first walk with an explicit stack of (vertex, next candidate)
    function void walk_preorder(vtx_t start, int unsigned n, row_t mask);
      vtx_t        stack_vtx  [MaxVertices];
      int unsigned stack_next [MaxVertices];
      vtx_t        order [$];
      row_t        seen;
      row_t        row;
      int unsigned depth;
      int unsigned top;
      int unsigned j;
      logic        found;
      if (start >= n) return;
      seen        = '0;
      seen[start] = 1'b1;
      order.push_back(start);
      stack_vtx[0]  = start;
      stack_next[0] = 0;
      depth         = 1;
      while (depth > 0) begin
        top   = depth - 1;
        row   = adjacency[stack_vtx[top]] & mask;
        j     = stack_next[top];
        found = 1'b0;
        // Scan for the lowest unvisited neighbour
        while (j < n && !found) begin
          if (row[j] && !seen[j]) found = 1'b1;
          else j++;
        end
        if (found && order.size() < MaxVertices && depth < MaxVertices) begin
          stack_next[top]   = j + 1;
          seen[j]           = 1'b1;
          order.push_back(vtx_t'(j));
          stack_vtx[depth]  = vtx_t'(j);
          stack_next[depth] = 0;
          depth++;
        end else begin
          depth--;
        end
      end
      foreach (order[i]) begin
        preorder_q.push_back('{vertex: order[i], last: (i == order.size() - 1)});
      end
    endfunction

    // Compare one output word with the oldest expected vertex
    task check_result(vtx_t vertex, logic last);
      visit_t want;
      if (preorder_q.size() == 0) begin
        report($sformatf("vertex %0d arrived with nothing expected", vertex));
      end else begin
        want = preorder_q.pop_front();
        if (vertex !== want.vertex) begin
          report($sformatf("visited_vertex %0d, expected %0d", vertex, want.vertex));
        end
        if (last !== want.last) begin
          report($sformatf("last %b on vertex %0d, expected %b", last, vertex, want.last));
        end
      end
    endtask

    task close_out();
      if (preorder_q.size() != 0) begin
        report($sformatf("%0d expected vertices never arrived", preorder_q.size()));
      end
    endtask
  endclass

  logic          clk;
  logic          rst_n;
  logic          cfg_we;
  cnt_t          cfg_wdata;
  logic          no_idle;
  int unsigned   words_sent;
  preorder_board board;

  dfsam_in_if  cmd_bus ();
  dfsam_out_if visit_bus ();

  dfs_adjacency_matrix u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_if       (cmd_bus),
    .out_if      (visit_bus)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic row_t pick_row();
    case ($urandom_range(0, 4))
      0: return row_t'($urandom);
      1: return row_t'(1) << $urandom_range(0, RowW - 1);
      2: return (row_t'(1) << $urandom_range(0, RowW - 1)) |
                (row_t'(1) << $urandom_range(0, RowW - 1));
      3: return '1;
      default: return '0;
    endcase
  endfunction

  // Present one command word and hold it until accepted
  task automatic send_word(logic opcode, vtx_t vertex, row_t row_bits);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_bus.valid    <= 1'b1;
    cmd_bus.opcode   <= opcode;
    cmd_bus.vertex   <= vertex;
    cmd_bus.row_bits <= row_bits;
    do @(posedge clk); while (!cmd_bus.ready);
    board.note_word(opcode, vertex, row_bits);
    words_sent++;
  endtask

  // Hold off the sender until every expected vertex is out, then settle
  task automatic drain(int unsigned settle);
    if (settle > 0 || board.preorder_q.size() != 0) begin
      cmd_bus.valid <= 1'b0;
    end
    while (board.preorder_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_vertex_count(cnt_t count);
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.vertex_count = count;
  endtask

  // Write a graph of some shape, then walk it one to three times
  task automatic build_and_walk(int unsigned n);
    int unsigned style;
    row_t        row;
    vtx_t        start;
    style = $urandom_range(0, 3);
    case (style)
      0: begin
        repeat ($urandom_range(1, n)) begin
          send_word(OpWrite, vtx_t'($urandom_range(0, n - 1)), pick_row());
        end
      end
      1: begin
        // Forward chain, deepest stack, with a few back edges
        for (int v = 0; v < n; v++) begin
          row = row_t'(1) << (v + 1);
          if ($urandom_range(0, 3) == 0) row = row | (row_t'(1) << $urandom_range(0, v));
          send_word(OpWrite, vtx_t'(v), row);
        end
      end
      2: begin
        // Backward chain, walked from the top vertex
        for (int v = n - 1; v >= 0; v--) begin
          row = (v > 0) ? (row_t'(1) << (v - 1)) : row_t'($urandom);
          send_word(OpWrite, vtx_t'(v), row);
        end
      end
      default: begin
        repeat ($urandom_range(1, n)) begin
          send_word(OpWrite, vtx_t'($urandom_range(0, n - 1)),
                    ~(row_t'(1) << $urandom_range(0, RowW - 1)));
        end
      end
    endcase
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 9) == 0) start = vtx_t'($urandom);
      else if (style == 1) start = '0;
      else if (style == 2) start = vtx_t'(n - 1);
      else start = vtx_t'($urandom_range(0, n - 1));
      send_word(OpRun, start, row_t'($urandom));
    end
  endtask

  // One configuration setting, mostly well-formed graphs, some noise
  task automatic run_phase(cnt_t count, int unsigned words);
    int unsigned stop;
    drain(SettleCycles);
    set_vertex_count(count);
    stop = words_sent + words;
    while (words_sent < stop) begin
      if ($urandom_range(0, 15) == 0) drain(0);
      if ($urandom_range(0, 9) < 7) begin
        build_and_walk(count);
      end else begin
        send_word(logic'($urandom_range(0, 1)), vtx_t'($urandom), pick_row());
      end
    end
  endtask

  // Output side: check accepted words, stall at random
  initial begin : visit_sink
    int unsigned stall;
    stall = 0;
    visit_bus.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (visit_bus.valid && visit_bus.ready) begin
        board.check_result(visit_bus.visited_vertex, visit_bus.last);
      end
      if (stall == 0 && $urandom_range(0, 3) == 0) stall = pick_gap();
      if (stall > 0) begin
        visit_bus.ready <= 1'b0;
        stall--;
      end else begin
        visit_bus.ready <= 1'b1;
      end
    end
  end

  // End the run when no word moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    wait (rst_n === 1'b1);
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((cmd_bus.valid && cmd_bus.ready) || (visit_bus.valid && visit_bus.ready)) quiet = 0;
      else quiet++;
    end
    $display("[%0t] no word moved for %0d cycles", $time, WatchdogLimit);
    $display("dfs_adjacency_matrix test failed");
    $finish;
  end

  initial begin : stimulus
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    cmd_bus.valid    <= 1'b0;
    cmd_bus.opcode   <= OpWrite;
    cmd_bus.vertex   <= '0;
    cmd_bus.row_bits <= '0;
    no_idle    = 1'b0;
    words_sent = 0;
    board      = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty graph, full rows, self loops, at the reset vertex count
    send_word(OpRun,   4'd0,  16'hFFFF);
    send_word(OpRun,   4'd15, 16'h0000);
    send_word(OpWrite, 4'd0,  16'hFFFF);
    send_word(OpRun,   4'd0,  16'h0000);
    send_word(OpWrite, 4'd15, 16'hFFFF);
    send_word(OpRun,   4'd15, 16'h0000);
    send_word(OpWrite, 4'd0,  16'h0000);
    send_word(OpRun,   4'd0,  16'h0000);
    send_word(OpWrite, 4'd5,  16'h0021);
    send_word(OpRun,   4'd5,  16'h0000);

    // Single vertex: rows masked, out-of-range writes and starts dropped
    drain(SettleCycles);
    set_vertex_count(cnt_t'(1));
    send_word(OpWrite, 4'd0,  16'hFFFF);
    send_word(OpRun,   4'd0,  16'h0000);
    send_word(OpRun,   4'd1,  16'h0000);
    send_word(OpWrite, 4'd9,  16'hFFFF);
    send_word(OpRun,   4'd15, 16'hFFFF);

    // Back to full size: the matrix keeps its rows
    drain(SettleCycles);
    set_vertex_count(cnt_t'(MaxVertices));
    send_word(OpRun,   4'd15, 16'h0000);
    send_word(OpRun,   4'd9,  16'h0000);

    run_phase(cnt_t'(MaxVertices), 30);
    run_phase(cnt_t'(1), 12);
    run_phase(cnt_t'(2), 15);
    run_phase(cnt_t'($urandom_range(3, 15)), 30);
    no_idle = 1'b1;
    run_phase(cnt_t'(MaxVertices), 25);
    no_idle = 1'b0;
    run_phase(cnt_t'($urandom_range(3, 15)), 30);

    drain(SettleCycles);
    board.close_out();
    if (board.mismatches == 0) begin
      $display("dfs_adjacency_matrix test passed");
    end else begin
      $display("dfs_adjacency_matrix test failed");
    end
    $finish;
  end

endmodule
